### hw/rtl/tgds_pkg.sv
// Shared types and constants of the torus grid diffusion step unit.
package tgds_pkg;

   localparam int OPCODE_W    = 2;
   localparam int ROW_W       = 5;
   localparam int COL_W       = 5;
   localparam int CONC_PORT_W = 24;
   localparam int STATUS_W    = 2;
   localparam int COEFF_W     = 14;
   localparam int DFRAC       = 16;
   localparam int PORTS       = 3;
   localparam int PADDR_W     = 2;
   localparam int PDATA_W     = 32;
   localparam int LANE_LAT    = 5;
   localparam int WIN         = 9;
   localparam int WIN_CENTER  = 4;

   localparam logic [COEFF_W-1:0] COEFF_RESET = 14'd6554;

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_STEP  = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_WRITE_ACK = 2'd0,
      STATUS_READ_DATA = 2'd1,
      STATUS_STEP_DONE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

endpackage

### hw/rtl/tgds_ram.sv
// Generic simple dual-port RAM with registered read.
module tgds_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/tgds_lane.sv
// One metabolite lane: pipelined 8-neighbour diffusion update of one value.
module tgds_lane #(
   parameter int CONC_BITS = 24
) (
   input  logic                                          clock,
   input  logic [tgds_pkg::COEFF_W-1:0]                  coeff,
   input  logic [tgds_pkg::WIN-1:0][CONC_BITS-1:0]       win,
   output logic [CONC_BITS-1:0]                          result
);

   localparam int PAIR_W = CONC_BITS + 1;
   localparam int SUM_W  = CONC_BITS + 3;
   localparam int DIFF_W = CONC_BITS + 4;
   localparam int PROD_W = DIFF_W + tgds_pkg::COEFF_W + 1;
   localparam int N_W    = PROD_W + 1;
   localparam int Q_W    = N_W - 1 - tgds_pkg::DFRAC;

   logic [3:0][PAIR_W-1:0]     pair_ff, pair_in;
   logic [CONC_BITS-1:0]       v1_ff, v2_ff, v3_ff, v4_ff;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic signed [DIFF_W-1:0]   diff_ff, diff_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [tgds_pkg::COEFF_W:0] coeff_s;
   logic [CONC_BITS-1:0]       result_ff, result_in;
   logic signed [N_W-1:0]      n_val;
   logic [Q_W-1:0]             q_val;

   always_comb begin
      pair_in[0] = PAIR_W'(win[0]) + PAIR_W'(win[1]);
      pair_in[1] = PAIR_W'(win[2]) + PAIR_W'(win[3]);
      pair_in[2] = PAIR_W'(win[5]) + PAIR_W'(win[6]);
      pair_in[3] = PAIR_W'(win[7]) + PAIR_W'(win[8]);
      sum_in     = (SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]))
                 + (SUM_W'(pair_ff[2]) + SUM_W'(pair_ff[3]));
      diff_in    = $signed(DIFF_W'(sum_ff)) - $signed(DIFF_W'({v2_ff, 3'b000}));
      coeff_s    = $signed({1'b0, coeff});
      prod_in    = PROD_W'(coeff_s) * PROD_W'(diff_ff);
      n_val      = $signed(N_W'({v4_ff, {tgds_pkg::DFRAC{1'b0}}})) + N_W'(prod_ff);
      q_val      = n_val[N_W-2:tgds_pkg::DFRAC];
      if (n_val[N_W-1]) begin
         result_in = '0;
      end else if (|q_val[Q_W-1:CONC_BITS]) begin
         result_in = '1;
      end else begin
         result_in = q_val[CONC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      pair_ff   <= pair_in;
      v1_ff     <= win[tgds_pkg::WIN_CENTER];
      sum_ff    <= sum_in;
      v2_ff     <= v1_ff;
      diff_ff   <= diff_in;
      v3_ff     <= v2_ff;
      prod_ff   <= prod_in;
      v4_ff     <= v3_ff;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

### hw/rtl/tgds_merge.sv
// Merge stage: packs the lane results into one cell word for write-back.
module tgds_merge #(
   parameter int CONC_BITS       = 24,
   parameter int NUM_METABOLITES = 3,
   parameter int ADDR_W          = 11
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic [NUM_METABOLITES-1:0][CONC_BITS-1:0]       lane_result,
   input  tgds_pkg::tag_type                               tag_in,
   input  logic [ADDR_W-1:0]                               addr_in,
   output tgds_pkg::tag_type                               tag_out,
   output logic [ADDR_W-1:0]                               addr_out,
   output logic [NUM_METABOLITES*CONC_BITS-1:0]            data_out
);

   tgds_pkg::tag_type                      tag_ff, tag_in_q;
   logic [ADDR_W-1:0]                      addr_ff;
   logic [NUM_METABOLITES*CONC_BITS-1:0]   data_ff, data_in;

   always_comb begin
      tag_in_q = tag_in;
      for (int m = 0; m < NUM_METABOLITES; m++) begin
         data_in[m*CONC_BITS +: CONC_BITS] = lane_result[m];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in_q;
      end
      addr_ff <= addr_in;
      data_ff <= data_in;
   end

   assign tag_out  = tag_ff;
   assign addr_out = addr_ff;
   assign data_out = data_ff;

endmodule

### hw/rtl/torus_grid_diffusion_step_unit.sv
// Torus grid diffusion step unit: cell store, scan sequencer, lanes and write-back.
// Write and read requests are taken one per cycle while busy is low; a write is
// acknowledged and a read returns its cell on rsp_strobe in the cycle after start.
// A step request holds busy high until its last result is written back: the single
// read port of the cell memory scans the grid with one wrapped row and column on
// each side, one cell per cycle, while a line buffer and a 3x3 window feed one
// lane per metabolite; the result of the step lands in the other bank, which then
// becomes the active one. rsp_strobe lasts one cycle and cannot be held off. The
// cell memory has no clearing pass: cells must be written before they are read
// or stepped over.
module torus_grid_diffusion_step_unit #(
   parameter int GRID_HEIGHT     = 32,
   parameter int GRID_WIDTH      = 32,
   parameter int CONC_BITS       = 24,
   parameter int NUM_METABOLITES = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [tgds_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [tgds_pkg::ROW_W-1:0]          req_row,
   input  logic [tgds_pkg::COL_W-1:0]          req_col,
   input  logic [tgds_pkg::CONC_PORT_W-1:0]    req_conc_a_in,
   input  logic [tgds_pkg::CONC_PORT_W-1:0]    req_conc_b_in,
   input  logic [tgds_pkg::CONC_PORT_W-1:0]    req_conc_c_in,
   output logic                                rsp_strobe,
   output logic [tgds_pkg::STATUS_W-1:0]       rsp_status,
   output logic [tgds_pkg::CONC_PORT_W-1:0]    rsp_conc_a_out,
   output logic [tgds_pkg::CONC_PORT_W-1:0]    rsp_conc_b_out,
   output logic [tgds_pkg::CONC_PORT_W-1:0]    rsp_conc_c_out,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tgds_pkg::PADDR_W-1:0]        paddr,
   input  logic [tgds_pkg::PDATA_W-1:0]        pwdata,
   output logic [tgds_pkg::PDATA_W-1:0]        prdata,
   output logic                                pready
);

   localparam int CELLS    = GRID_HEIGHT * GRID_WIDTH;
   localparam int CELL_W   = NUM_METABOLITES * CONC_BITS;
   localparam int ADDR_W   = $clog2(2 * CELLS);
   localparam int ROWI_W   = $clog2(GRID_HEIGHT);
   localparam int COLI_W   = $clog2(GRID_WIDTH);
   localparam int EXT_RW   = $clog2(GRID_HEIGHT + 2);
   localparam int EXT_CW   = $clog2(GRID_WIDTH + 2);
   localparam int ROW_LAST = GRID_HEIGHT + 1;
   localparam int COL_LAST = GRID_WIDTH + 1;
   localparam int ROW_TAB  = 2 ** tgds_pkg::ROW_W;
   localparam int COL_TAB  = 2 ** tgds_pkg::COL_W;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic bank,
                                                   input logic [ROWI_W-1:0] r,
                                                   input logic [COLI_W-1:0] c);
      logic [ADDR_W-1:0] base;
      base = bank ? ADDR_W'(CELLS) : '0;
      return base + ADDR_W'(r) * ADDR_W'(GRID_WIDTH) + ADDR_W'(c);
   endfunction

   function automatic logic [ROWI_W-1:0] ext_row(input logic [EXT_RW-1:0] e);
      logic [ROWI_W-1:0] r;
      if (e == '0) begin
         r = ROWI_W'(GRID_HEIGHT - 1);
      end else if (e == EXT_RW'(ROW_LAST)) begin
         r = '0;
      end else begin
         r = ROWI_W'(e - 1'b1);
      end
      return r;
   endfunction

   function automatic logic [COLI_W-1:0] ext_col(input logic [EXT_CW-1:0] k);
      logic [COLI_W-1:0] c;
      if (k == '0) begin
         c = COLI_W'(GRID_WIDTH - 1);
      end else if (k == EXT_CW'(COL_LAST)) begin
         c = '0;
      end else begin
         c = COLI_W'(k - 1'b1);
      end
      return c;
   endfunction

   tgds_pkg::state_type                   state_ff, state_in;
   logic [EXT_RW-1:0]                     e_ff, e_in;
   logic [EXT_CW-1:0]                     k_ff, k_in;
   logic                                  active_ff, active_in;
   logic [tgds_pkg::COEFF_W-1:0]          coeff_ff, coeff_in;
   logic                                  iss_valid_ff, iss_valid_in;
   logic [EXT_RW-1:0]                     iss_e_ff;
   logic [EXT_CW-1:0]                     iss_k_ff;
   logic [2:0][2:0][CELL_W-1:0]           win_ff, win_in;
   tgds_pkg::tag_type                     win_tag_ff, win_tag_in;
   logic [ADDR_W-1:0]                     win_addr_ff, win_addr_in;
   tgds_pkg::tag_type                     tag_pipe_ff [tgds_pkg::LANE_LAT];
   tgds_pkg::tag_type                     tag_pipe_in [tgds_pkg::LANE_LAT];
   logic [ADDR_W-1:0]                     addr_pipe_ff [tgds_pkg::LANE_LAT];
   logic [ADDR_W-1:0]                     addr_pipe_in [tgds_pkg::LANE_LAT];
   logic                                  rsp_strobe_ff, rsp_strobe_in;
   tgds_pkg::status_type                  rsp_status_ff, rsp_status_in;
   logic                                  rsp_read_ff, rsp_read_in;

   logic                                  accept;
   logic                                  scan_active;
   logic                                  scan_last;
   logic                                  step_done;
   logic                                  cfg_write;
   logic [ROWI_W-1:0]                     row_mod_tab [ROW_TAB];
   logic [COLI_W-1:0]                     col_mod_tab [COL_TAB];
   logic [ADDR_W-1:0]                     req_addr;
   logic [CELL_W-1:0]                     req_cell;
   logic [tgds_pkg::PORTS-1:0][tgds_pkg::CONC_PORT_W-1:0] req_conc;
   logic [tgds_pkg::PORTS-1:0][tgds_pkg::CONC_PORT_W-1:0] rsp_conc;

   logic                                  mem_wr_en;
   logic [ADDR_W-1:0]                     mem_wr_addr;
   logic [CELL_W-1:0]                     mem_wr_data;
   logic [ADDR_W-1:0]                     mem_rd_addr;
   logic [CELL_W-1:0]                     mem_rd_data;
   logic [2*CELL_W-1:0]                   lb_rd_data;

   logic [NUM_METABOLITES-1:0][tgds_pkg::WIN-1:0][CONC_BITS-1:0] lane_win;
   logic [NUM_METABOLITES-1:0][CONC_BITS-1:0]                     lane_result;
   tgds_pkg::tag_type                     mrg_tag;
   logic [ADDR_W-1:0]                     mrg_addr;
   logic [CELL_W-1:0]                     mrg_data;

   for (genvar gi = 0; gi < ROW_TAB; gi++) begin : g_row_tab
      assign row_mod_tab[gi] = ROWI_W'(gi % GRID_HEIGHT);
   end
   for (genvar gi = 0; gi < COL_TAB; gi++) begin : g_col_tab
      assign col_mod_tab[gi] = COLI_W'(gi % GRID_WIDTH);
   end

   assign req_conc = {req_conc_c_in, req_conc_b_in, req_conc_a_in};

   for (genvar gm = 0; gm < NUM_METABOLITES; gm++) begin : g_req_cell
      if (gm < tgds_pkg::PORTS) begin : g_port
         assign req_cell[gm*CONC_BITS +: CONC_BITS] = CONC_BITS'(req_conc[gm]);
      end else begin : g_zero
         assign req_cell[gm*CONC_BITS +: CONC_BITS] = '0;
      end
   end

   for (genvar gp = 0; gp < tgds_pkg::PORTS; gp++) begin : g_rsp_conc
      if (gp < NUM_METABOLITES) begin : g_lane
         assign rsp_conc[gp] = rsp_read_ff ?
            tgds_pkg::CONC_PORT_W'(mem_rd_data[gp*CONC_BITS +: CONC_BITS]) : '0;
      end else begin : g_zero
         assign rsp_conc[gp] = '0;
      end
   end

   assign accept    = start && !busy;
   assign cfg_write = psel && penable && pwrite && pready;
   assign req_addr  = cell_addr(active_ff, row_mod_tab[req_row], col_mod_tab[req_col]);
   assign scan_last = (e_ff == EXT_RW'(ROW_LAST)) && (k_ff == EXT_CW'(COL_LAST));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tgds_pkg::ST_IDLE: begin
            if (accept && req_opcode == tgds_pkg::OP_STEP) begin
               state_in = tgds_pkg::ST_SCAN;
            end
         end
         tgds_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = tgds_pkg::ST_DRAIN;
            end
         end
         tgds_pkg::ST_DRAIN: begin
            if (mrg_tag.valid && mrg_tag.last) begin
               state_in = tgds_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tgds_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      busy        = 1'b1;
      scan_active = 1'b0;
      step_done   = 1'b0;
      case (state_ff)
         tgds_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         tgds_pkg::ST_SCAN: begin
            scan_active = 1'b1;
         end
         tgds_pkg::ST_DRAIN: begin
            step_done = mrg_tag.valid && mrg_tag.last;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_comb begin
      e_in = '0;
      k_in = '0;
      if (scan_active) begin
         if (k_ff == EXT_CW'(COL_LAST)) begin
            e_in = e_ff + 1'b1;
         end else begin
            e_in = e_ff;
            k_in = k_ff + 1'b1;
         end
      end
      active_in    = step_done ? ~active_ff : active_ff;
      coeff_in     = cfg_write ? pwdata[tgds_pkg::COEFF_W-1:0] : coeff_ff;
      iss_valid_in = scan_active;
   end

   assign mem_rd_addr = scan_active ? cell_addr(active_ff, ext_row(e_ff), ext_col(k_ff))
                                    : req_addr;

   // shift the column of three cells into the window
   always_comb begin
      win_in = win_ff;
      if (iss_valid_ff) begin
         win_in[2]    = win_ff[1];
         win_in[1]    = win_ff[0];
         win_in[0][0] = lb_rd_data[CELL_W-1:0];
         win_in[0][1] = lb_rd_data[2*CELL_W-1:CELL_W];
         win_in[0][2] = mem_rd_data;
      end
      win_tag_in.valid = iss_valid_ff && (iss_e_ff >= EXT_RW'(2)) && (iss_k_ff >= EXT_CW'(2));
      win_tag_in.last  = iss_valid_ff && (iss_e_ff == EXT_RW'(ROW_LAST))
                         && (iss_k_ff == EXT_CW'(COL_LAST));
      win_addr_in      = cell_addr(~active_ff, ROWI_W'(iss_e_ff - EXT_RW'(2)),
                                   COLI_W'(iss_k_ff - EXT_CW'(2)));
   end

   always_comb begin
      tag_pipe_in[0]  = win_tag_ff;
      addr_pipe_in[0] = win_addr_ff;
      for (int i = 1; i < tgds_pkg::LANE_LAT; i++) begin
         tag_pipe_in[i]  = tag_pipe_ff[i-1];
         addr_pipe_in[i] = addr_pipe_ff[i-1];
      end
   end

   always_comb begin
      rsp_strobe_in = step_done || (accept && (req_opcode == tgds_pkg::OP_WRITE
                                            || req_opcode == tgds_pkg::OP_READ));
      rsp_read_in   = accept && req_opcode == tgds_pkg::OP_READ;
      if (step_done) begin
         rsp_status_in = tgds_pkg::STATUS_STEP_DONE;
      end else if (req_opcode == tgds_pkg::OP_READ) begin
         rsp_status_in = tgds_pkg::STATUS_READ_DATA;
      end else begin
         rsp_status_in = tgds_pkg::STATUS_WRITE_ACK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tgds_pkg::ST_IDLE;
         e_ff          <= '0;
         k_ff          <= '0;
         active_ff     <= 1'b0;
         coeff_ff      <= tgds_pkg::COEFF_RESET;
         iss_valid_ff  <= 1'b0;
         win_tag_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_read_ff   <= 1'b0;
         for (int i = 0; i < tgds_pkg::LANE_LAT; i++) begin
            tag_pipe_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         e_ff          <= e_in;
         k_ff          <= k_in;
         active_ff     <= active_in;
         coeff_ff      <= coeff_in;
         iss_valid_ff  <= iss_valid_in;
         win_tag_ff    <= win_tag_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_read_ff   <= rsp_read_in;
         for (int i = 0; i < tgds_pkg::LANE_LAT; i++) begin
            tag_pipe_ff[i] <= tag_pipe_in[i];
         end
      end
      iss_e_ff      <= e_ff;
      iss_k_ff      <= k_ff;
      win_ff        <= win_in;
      win_addr_ff   <= win_addr_in;
      rsp_status_ff <= rsp_status_in;
      for (int i = 0; i < tgds_pkg::LANE_LAT; i++) begin
         addr_pipe_ff[i] <= addr_pipe_in[i];
      end
   end

   assign mem_wr_en   = mrg_tag.valid || (accept && req_opcode == tgds_pkg::OP_WRITE);
   assign mem_wr_addr = mrg_tag.valid ? mrg_addr : req_addr;
   assign mem_wr_data = mrg_tag.valid ? mrg_data : req_cell;

   tgds_ram #(
      .WIDTH (CELL_W),
      .DEPTH (2 * CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   tgds_ram #(
      .WIDTH (2 * CELL_W),
      .DEPTH (GRID_WIDTH + 2)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (iss_valid_ff),
      .wr_addr (iss_k_ff),
      .wr_data ({mem_rd_data, lb_rd_data[2*CELL_W-1:CELL_W]}),
      .rd_addr (k_ff),
      .rd_data (lb_rd_data)
   );

   for (genvar gm = 0; gm < NUM_METABOLITES; gm++) begin : g_lane
      for (genvar gr = 0; gr < 3; gr++) begin : g_win_row
         for (genvar gc = 0; gc < 3; gc++) begin : g_win_col
            assign lane_win[gm][gr*3+gc] = win_ff[gc][gr][gm*CONC_BITS +: CONC_BITS];
         end
      end

      tgds_lane #(
         .CONC_BITS (CONC_BITS)
      ) u_lane (
         .clock  (clock),
         .coeff  (coeff_ff),
         .win    (lane_win[gm]),
         .result (lane_result[gm])
      );
   end

   tgds_merge #(
      .CONC_BITS       (CONC_BITS),
      .NUM_METABOLITES (NUM_METABOLITES),
      .ADDR_W          (ADDR_W)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .lane_result (lane_result),
      .tag_in      (tag_pipe_ff[tgds_pkg::LANE_LAT-1]),
      .addr_in     (addr_pipe_ff[tgds_pkg::LANE_LAT-1]),
      .tag_out     (mrg_tag),
      .addr_out    (mrg_addr),
      .data_out    (mrg_data)
   );

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_conc_a_out = rsp_conc[0];
   assign rsp_conc_b_out = rsp_conc[1];
   assign rsp_conc_c_out = rsp_conc[2];
   assign prdata         = tgds_pkg::PDATA_W'(coeff_ff);
   assign pready         = 1'b1;

endmodule

### hw/rtl/tgds_checker.sv
// Port-level checker for the torus grid diffusion step unit, with its bind.
module tgds_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [tgds_pkg::OPCODE_W-1:0]     req_opcode,
   input logic                              rsp_strobe,
   input logic [tgds_pkg::STATUS_W-1:0]     rsp_status,
   input logic [tgds_pkg::CONC_PORT_W-1:0]  rsp_conc_a_out,
   input logic [tgds_pkg::CONC_PORT_W-1:0]  rsp_conc_b_out,
   input logic [tgds_pkg::CONC_PORT_W-1:0]  rsp_conc_c_out
);

   a_write_ack: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == tgds_pkg::OP_WRITE)
      |=> (rsp_strobe && rsp_status == tgds_pkg::STATUS_WRITE_ACK))
      else $error("write request not acknowledged in the next cycle");

   a_read_data: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == tgds_pkg::OP_READ)
      |=> (rsp_strobe && rsp_status == tgds_pkg::STATUS_READ_DATA))
      else $error("read request without read data in the next cycle");

   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == tgds_pkg::OP_STEP) |=> busy)
      else $error("step request did not raise busy");

   a_step_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy))
      |-> (rsp_strobe && rsp_status == tgds_pkg::STATUS_STEP_DONE))
      else $error("busy dropped without a step-done result");

   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != tgds_pkg::STATUS_READ_DATA)
      |-> (rsp_conc_a_out == '0 && rsp_conc_b_out == '0 && rsp_conc_c_out == '0))
      else $error("non-read result carries concentration data");

endmodule

bind torus_grid_diffusion_step_unit tgds_checker u_tgds_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_opcode     (req_opcode),
   .rsp_strobe     (rsp_strobe),
   .rsp_status     (rsp_status),
   .rsp_conc_a_out (rsp_conc_a_out),
   .rsp_conc_b_out (rsp_conc_b_out),
   .rsp_conc_c_out (rsp_conc_c_out)
);
